FILE: rtl/core/nrp_pkg.sv
package nrp_pkg;

   localparam logic [2:0] HEADER_LEN  = 3'd6;
   localparam logic [2:0] POS_SAT     = 3'd7;
   localparam logic [2:0] COMMA_SAT   = 3'd7;
   localparam logic [2:0] LAT_COMMA   = 3'd2;
   localparam logic [2:0] LON_COMMA   = 3'd4;
   localparam logic [3:0] LAT_LEN     = 4'd9;
   localparam logic [3:0] LON_LEN     = 4'd10;
   localparam logic [3:0] LAT_DEG_END = 4'd2;
   localparam logic [3:0] LON_DEG_END = 4'd3;

   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [11:0] SEC_PER_DEG = 12'd3600;
   localparam logic [5:0]  SEC_PER_MIN = 6'd60;
   // floor(frac*60/10000) == (frac*FRAC_RECIP) >> 24 for frac < 10000
   localparam logic [16:0] FRAC_RECIP  = 17'd100665;

   localparam int LAT_W = 19;
   localparam int LON_W = 22;

   typedef enum logic [1:0] {
      WIN_NONE,
      WIN_LAT,
      WIN_LON
   } win_kind_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_char;
   } req_item_type;

   typedef struct packed {
      logic             header_matched;
      logic             aborted;
      logic             lat_valid;
      logic [LAT_W-1:0] lat_arcsec;
      logic             lon_valid;
      logic [LON_W-1:0] lon_arcsec;
   } rsp_item_type;

   typedef struct packed {
      logic        ok;
      logic [9:0]  deg;
      logic [6:0]  min;
      logic [13:0] frac;
   } coord_raw_type;

   typedef struct packed {
      logic        ok;
      logic [21:0] deg_sec;
      logic [12:0] min_sec;
      logic [6:0]  frac_sec;
   } coord_prod_type;

   function automatic logic [7:0] header_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0: ch = 8'h24;   // $
         3'd1: ch = 8'h47;   // G
         3'd2: ch = 8'h50;   // P
         3'd3: ch = 8'h52;   // R
         3'd4: ch = 8'h4D;   // M
         3'd5: ch = 8'h43;   // C
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/core/nrp_if.sv
interface nrp_req_if;
   import nrp_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface nrp_rsp_if;
   import nrp_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/nmea_rmc_position_parser.sv
// Streaming $GPRMC position parser. One character is taken per clock unless input is
// held off; the item with last_char set closes the string and produces exactly one
// result, which passes through the a and b stage registers to the output register.
// Parser state updates per accepted character; the arc-second conversion runs in two
// registered steps behind it (constant multiplies, then the sum). The only thing that
// holds off input is a result sitting unread in the output register: req_ch.ready
// follows rsp_ch.ready whenever that register is full, otherwise it stays high.
module nmea_rmc_position_parser (
   input logic        clock,
   input logic        reset,
   nrp_req_if.sink    req_ch,
   nrp_rsp_if.source  rsp_ch
);
   import nrp_pkg::*;

   // parser state
   logic [2:0]    pos_ff, pos_in;
   logic          header_ok_ff, header_ok_in;
   logic [2:0]    comma_ff, comma_in;
   logic [3:0]    offset_ff, offset_in;
   win_kind_type  kind_ff, kind_in;
   logic [9:0]    deg_ff, deg_in;
   logic [6:0]    min_ff, min_in;
   logic [13:0]   frac_ff, frac_in;
   logic          bad_ff, bad_in;
   coord_raw_type lat_ff, lat_in;
   coord_raw_type lon_ff, lon_in;
   logic          newline_ff, newline_in;
   logic          abort_ff, abort_in;

   // result pipeline
   logic           a_valid_ff, a_hdr_ff, a_abort_ff;
   coord_raw_type  a_lat_ff, a_lon_ff;
   logic           b_valid_ff, b_hdr_ff, b_abort_ff;
   coord_prod_type b_lat_ff, b_lon_ff;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_data_ff;

   logic          advance, accept, closing;
   logic          matched, abort_out;
   logic [7:0]    c;
   logic          is_digit;
   logic [3:0]    d;
   logic          is_lat;
   logic [3:0]    win_len, deg_end, off;

   coord_raw_type  a_lat_in, a_lon_in;
   coord_prod_type b_lat_in, b_lon_in;
   rsp_item_type   rsp_data_in;
   logic [LAT_W-1:0] lat_sum;
   logic [LON_W-1:0] lon_sum;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;
   assign closing      = accept && req_ch.data.last_char;

   assign c        = req_ch.data.char_byte;
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign d        = is_digit ? c[3:0] : 4'd0;

   always_comb begin
      pos_in       = (pos_ff == POS_SAT) ? pos_ff : pos_ff + 3'd1;
      header_ok_in = header_ok_ff;
      comma_in     = comma_ff;
      offset_in    = offset_ff;
      kind_in      = kind_ff;
      deg_in       = deg_ff;
      min_in       = min_ff;
      frac_in      = frac_ff;
      bad_in       = bad_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      newline_in   = newline_ff;
      abort_in     = abort_ff;
      is_lat       = (kind_ff == WIN_LAT);
      win_len      = is_lat ? LAT_LEN : LON_LEN;
      deg_end      = is_lat ? LAT_DEG_END : LON_DEG_END;
      off          = offset_ff + 4'd1;

      if (pos_ff < HEADER_LEN && c != header_char(pos_ff)) begin
         header_ok_in = 1'b0;
      end

      if (header_ok_in && !newline_ff && !abort_ff) begin
         if (kind_ff == WIN_LAT || kind_ff == WIN_LON) begin
            offset_in = off;
            if (off == 4'd1 && c == CHAR_COMMA) begin
               // empty coordinate field
               abort_in = 1'b1;
               kind_in  = WIN_NONE;
            end else begin
               // the decimal point position is skipped
               if (off != deg_end + 4'd3) begin
                  if (!is_digit) begin
                     bad_in = 1'b1;
                  end else if (off <= deg_end) begin
                     deg_in = 10'(deg_ff * 10'd10 + 10'(d));
                  end else if (off <= deg_end + 4'd2) begin
                     min_in = 7'(min_ff * 7'd10 + 7'(d));
                  end else begin
                     frac_in = 14'(frac_ff * 14'd10 + 14'(d));
                  end
               end
               if (off >= win_len) begin
                  if (is_lat) begin
                     lat_in = '{ok: !bad_in, deg: deg_in, min: min_in, frac: frac_in};
                  end else begin
                     lon_in = '{ok: !bad_in, deg: deg_in, min: min_in, frac: frac_in};
                  end
                  kind_in   = WIN_NONE;
                  offset_in = 4'd0;
               end
            end
         end else if (c == CHAR_NEWLINE) begin
            newline_in = 1'b1;
         end else if (c == CHAR_COMMA) begin
            if (comma_ff == LAT_COMMA || comma_ff == LON_COMMA) begin
               kind_in   = (comma_ff == LAT_COMMA) ? WIN_LAT : WIN_LON;
               offset_in = 4'd0;
               deg_in    = '0;
               min_in    = '0;
               frac_in   = '0;
               bad_in    = 1'b0;
            end
            if (comma_ff != COMMA_SAT) begin
               comma_in = comma_ff + 3'd1;
            end
         end
      end
   end

   // result at end of string; a still-open window means it was cut off
   always_comb begin
      matched   = header_ok_in && (pos_in == POS_SAT);
      abort_out = abort_in || kind_in == WIN_LAT || kind_in == WIN_LON;
      a_lat_in  = lat_in;
      a_lon_in  = lon_in;
      a_lat_in.ok = matched && !abort_out && lat_in.ok;
      a_lon_in.ok = matched && !abort_out && lon_in.ok;
   end

   always_ff @(posedge clock) begin
      if (reset || closing) begin
         pos_ff       <= '0;
         header_ok_ff <= 1'b1;
         comma_ff     <= '0;
         offset_ff    <= '0;
         kind_ff      <= WIN_NONE;
         deg_ff       <= '0;
         min_ff       <= '0;
         frac_ff      <= '0;
         bad_ff       <= 1'b0;
         lat_ff       <= '0;
         lon_ff       <= '0;
         newline_ff   <= 1'b0;
         abort_ff     <= 1'b0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         header_ok_ff <= header_ok_in;
         comma_ff     <= comma_in;
         offset_ff    <= offset_in;
         kind_ff      <= kind_in;
         deg_ff       <= deg_in;
         min_ff       <= min_in;
         frac_ff      <= frac_in;
         bad_ff       <= bad_in;
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         newline_ff   <= newline_in;
         abort_ff     <= abort_in;
      end
   end

   // constant multiplies
   always_comb begin
      b_lat_in.ok       = a_lat_ff.ok;
      b_lat_in.deg_sec  = 22'(a_lat_ff.deg) * 22'(SEC_PER_DEG);
      b_lat_in.min_sec  = 13'(a_lat_ff.min) * 13'(SEC_PER_MIN);
      b_lat_in.frac_sec = 7'((31'(a_lat_ff.frac) * 31'(FRAC_RECIP)) >> 24);
      b_lon_in.ok       = a_lon_ff.ok;
      b_lon_in.deg_sec  = 22'(a_lon_ff.deg) * 22'(SEC_PER_DEG);
      b_lon_in.min_sec  = 13'(a_lon_ff.min) * 13'(SEC_PER_MIN);
      b_lon_in.frac_sec = 7'((31'(a_lon_ff.frac) * 31'(FRAC_RECIP)) >> 24);
   end

   always_comb begin
      lat_sum = LAT_W'(b_lat_ff.deg_sec + 22'(b_lat_ff.min_sec) + 22'(b_lat_ff.frac_sec));
      lon_sum = LON_W'(b_lon_ff.deg_sec + 22'(b_lon_ff.min_sec) + 22'(b_lon_ff.frac_sec));
      rsp_data_in.header_matched = b_hdr_ff;
      rsp_data_in.aborted        = b_abort_ff;
      rsp_data_in.lat_valid      = b_lat_ff.ok;
      rsp_data_in.lat_arcsec     = b_lat_ff.ok ? lat_sum : '0;
      rsp_data_in.lon_valid      = b_lon_ff.ok;
      rsp_data_in.lon_arcsec     = b_lon_ff.ok ? lon_sum : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= closing;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_hdr_ff    <= matched;
         a_abort_ff  <= matched && abort_out;
         a_lat_ff    <= a_lat_in;
         a_lon_ff    <= a_lon_in;
         b_hdr_ff    <= a_hdr_ff;
         b_abort_ff  <= a_abort_ff;
         b_lat_ff    <= b_lat_in;
         b_lon_ff    <= b_lon_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

FILE: rtl/core/nrp_checker.sv
module nrp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input nrp_pkg::rsp_item_type rsp_data
);
   import nrp_pkg::*;

   localparam logic [LAT_W-1:0] LAT_MAX = LAT_W'(362399);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input is only held off by a full output register
   a_ready_only_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.aborted || rsp_data.lat_valid || rsp_data.lon_valid)
      |-> rsp_data.header_matched && !(rsp_data.aborted &&
          (rsp_data.lat_valid || rsp_data.lon_valid)))
      else $error("result flags inconsistent");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.lat_valid || rsp_data.lat_arcsec == '0) &&
                    (rsp_data.lon_valid || rsp_data.lon_arcsec == '0))
      else $error("invalid coordinate has nonzero value");

   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.lat_valid |-> rsp_data.lat_arcsec <= LAT_MAX)
      else $error("latitude out of range");

endmodule

bind nmea_rmc_position_parser nrp_checker u_nrp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
